/* sv/chf_pkg.sv */
// ----------------------------------------------------------------------------
// chf_pkg
// Shared types and constants of the compass heading filter.
// ----------------------------------------------------------------------------
package chf_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned AngW  = 40;
  localparam int unsigned TableLen = 24;
  localparam int unsigned FullTurn = 36000;
  localparam int unsigned HalfTurn = 18000;

  typedef enum logic [1:0] {
    REG_OFFSET_X = 2'd0,
    REG_OFFSET_Z = 2'd1,
    REG_GAIN     = 2'd2
  } reg_idx_t;

  // atan(2^-i) in centidegrees times 2^16
  function automatic logic signed [AngW-1:0] atan_entry(input logic [4:0] i);
    logic signed [AngW-1:0] r;
    case (i)
      5'd0:  r = 40'sd294912000;
      5'd1:  r = 40'sd174096719;
      5'd2:  r = 40'sd91987925;
      5'd3:  r = 40'sd46694507;
      5'd4:  r = 40'sd23437865;
      5'd5:  r = 40'sd11730358;
      5'd6:  r = 40'sd5866610;
      5'd7:  r = 40'sd2933484;
      5'd8:  r = 40'sd1466764;
      5'd9:  r = 40'sd733385;
      5'd10: r = 40'sd366693;
      5'd11: r = 40'sd183346;
      5'd12: r = 40'sd91673;
      5'd13: r = 40'sd45837;
      5'd14: r = 40'sd22918;
      5'd15: r = 40'sd11459;
      5'd16: r = 40'sd5730;
      5'd17: r = 40'sd2865;
      5'd18: r = 40'sd1432;
      5'd19: r = 40'sd716;
      5'd20: r = 40'sd358;
      5'd21: r = 40'sd179;
      5'd22: r = 40'sd90;
      5'd23: r = 40'sd45;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* sv/chf_if.sv */
// ----------------------------------------------------------------------------
// chf_if
// Valid/ready channel interfaces of the compass heading filter.
// ----------------------------------------------------------------------------
interface chf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] raw_x;
  logic signed [15:0] raw_z;
  modport source (output valid, raw_x, raw_z, input ready);
  modport sink   (input valid, raw_x, raw_z, output ready);
endinterface

interface chf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] corrected_x;
  logic signed [15:0] corrected_z;
  logic        [15:0] heading_centideg;
  modport source (output valid, corrected_x, corrected_z, heading_centideg, input ready);
  modport sink   (input valid, corrected_x, corrected_z, heading_centideg, output ready);
endinterface

interface chf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/chf_smooth.sv */
// ----------------------------------------------------------------------------
// chf_smooth
// Bit-serial EMA step: s += round(gain * (t - s) / 2^16), one gain bit a cycle.
// ----------------------------------------------------------------------------
module chf_smooth #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                start,
  input  logic [15:0]         gain,
  input  logic signed [15:0]  corr,
  input  logic signed [39:0]  s_in,
  output logic signed [39:0]  s_out,
  output logic                done
);
  // product accumulator: 40-bit diff (fits 41) times 16-bit gain
  logic signed [57:0] acc_r, acc_nxt;
  logic signed [41:0] diff_r, diff_nxt;
  logic [15:0]        g_r, g_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic signed [41:0] tgt;
  logic signed [57:0] rnd;

  assign tgt = 42'(corr) <<< FRACTION_BITS;

  // shift-add: multiply one gain bit per cycle, msb first
  always_comb begin
    acc_nxt  = acc_r;
    diff_nxt = diff_r;
    g_nxt    = g_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      acc_nxt  = '0;
      diff_nxt = tgt - 42'(s_in);
      g_nxt    = gain;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = (acc_r <<< 1) + (g_r[15] ? 58'(diff_r) : 58'sd0);
      g_nxt   = g_r << 1;
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd15) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    diff_r <= diff_nxt;
    g_r    <= g_nxt;
    cnt_r  <= cnt_nxt;
    busy_r <= start ? 1'b1 : busy_nxt;
  end

  // product is complete once all 16 gain bits are in
  assign rnd   = acc_r + 58'sd32768;
  assign done  = (cnt_r == 5'd16);
  assign s_out = s_in + 40'(rnd >>> 16);
endmodule

/* sv/compass_heading_filter_top.sv */
// ----------------------------------------------------------------------------
// compass_heading_filter_top
// Hard-iron corrected magnetometer heading with exponential smoothing.
// ----------------------------------------------------------------------------
// A word runs from acceptance through the bit-serial gain multiply of the two
// filters and the filter update (ST_MUL), then ANGLE_ITERATIONS CORDIC
// iterations, one a cycle (at most 24, ST_ROT), and then rounding and wrap
// (ST_RND) into the result register. A zero vector skips the iterations. One
// word is worked at a time; the result register holds the finished word until
// taken, and the next word is accepted meanwhile, once the machine has passed
// through ST_OUT back to ST_IDLE. A result still waiting holds the rounding
// cycle of the next word.
module compass_heading_filter_top #(
  parameter int unsigned ANGLE_ITERATIONS = 16,
  parameter int unsigned FRACTION_BITS    = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  chf_in_if.sink    in_ch,
  chf_out_if.source out_ch,
  chf_cfg_if.sink   cfg_ch
);
  import chf_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_ROT   = 5'b00100,
    ST_RND   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic signed [15:0] off_x_r, off_z_r;
  logic [15:0]        gain_r;
  logic signed [39:0] sx_r, sz_r;
  logic signed [15:0] cx_r, cz_r;
  logic signed [41:0] cx42_r, cy42_r;
  logic signed [AngW:0] ang_r;
  logic [4:0]         it_r;
  logic [15:0]        cd_r;
  logic               ov_r;
  logic signed [15:0] ox_r, oz_r;
  logic [15:0]        oh_r;
  logic               start;
  logic               in_fire;
  logic signed [39:0] sx_new, sz_new;
  logic               dx, dz;
  logic signed [41:0] xs, ys;
  logic signed [AngW:0] rnd;
  logic signed [24:0] cdw;

  // config writes
  assign cfg_ch.ready = rst_n;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= 16'sd400;
      off_z_r <= 16'sd100;
      gain_r  <= 16'd655;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_OFFSET_X: off_x_r <= cfg_ch.data;
        REG_OFFSET_Z: off_z_r <= cfg_ch.data;
        REG_GAIN:     gain_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = rst_n && (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign start       = in_fire;

  chf_smooth #(.FRACTION_BITS(FRACTION_BITS)) u_sx (
    .clk(clk), .start(start), .gain(gain_r),
    .corr(in_ch.raw_x - off_x_r), .s_in(sx_r), .s_out(sx_new), .done(dx));
  chf_smooth #(.FRACTION_BITS(FRACTION_BITS)) u_sz (
    .clk(clk), .start(start), .gain(gain_r),
    .corr(in_ch.raw_z - off_z_r), .s_in(sz_r), .s_out(sz_new), .done(dz));

  assign xs  = cx42_r >>> it_r;
  assign ys  = cy42_r >>> it_r;
  assign rnd = (ang_r + 41'sd32768) >>> 16;
  assign cdw = 25'(rnd);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_MUL;
      ST_MUL:  if (dx) state_nxt = ST_ROT;
      ST_ROT:  if (ov_r) state_nxt = ST_RND;
               else if (32'(it_r) == ANGLE_ITERATIONS - 1 || it_r == 5'd23)
                 state_nxt = ST_RND;
      ST_RND:  if (!out_ch.valid || out_ch.ready) state_nxt = ST_OUT;
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sx_r <= '0;
      sz_r <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        cx_r <= in_ch.raw_x - off_x_r;
        cz_r <= in_ch.raw_z - off_z_r;
      end
      if (state_r == ST_MUL && dx && dz) begin
        sx_r <= sx_new;
        sz_r <= sz_new;
        // zero vector gives heading 0
        ov_r <= (sx_new == 0) && (sz_new == 0);
        it_r <= '0;
        if (sz_new < 0) begin
          cx42_r <= -42'(sz_new);
          cy42_r <= -42'(sx_new);
          ang_r  <= 41'(HalfTurn) <<< 16;
        end else begin
          cx42_r <= 42'(sz_new);
          cy42_r <= 42'(sx_new);
          ang_r  <= '0;
        end
      end
      // one CORDIC iteration
      if (state_r == ST_ROT && !ov_r) begin
        it_r <= it_r + 5'd1;
        if (cy42_r > 0) begin
          cx42_r <= cx42_r + ys;
          cy42_r <= cy42_r - xs;
          ang_r  <= ang_r + 41'(atan_entry(it_r));
        end else begin
          cx42_r <= cx42_r - ys;
          cy42_r <= cy42_r + xs;
          ang_r  <= ang_r - 41'(atan_entry(it_r));
        end
      end
      // round, wrap into 0..35999; otherwise drop the word once taken
      if (state_r == ST_RND && state_nxt == ST_OUT) begin
        ox_r <= cx_r;
        oz_r <= cz_r;
        if (ov_r) oh_r <= '0;
        else if (cdw < 0) oh_r <= 16'(cdw + 25'(FullTurn));
        else if (cdw >= 25'(FullTurn)) oh_r <= 16'(cdw - 25'(FullTurn));
        else oh_r <= 16'(cdw);
        out_ch.valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  assign cd_r = oh_r;
  assign out_ch.corrected_x      = ox_r;
  assign out_ch.corrected_z      = oz_r;
  assign out_ch.heading_centideg = cd_r;
endmodule
